[design/srde_pkg.sv]
// Shared types and constants of the scaled raster draw engine.
`default_nettype none
package srde_pkg;

    localparam int COORD_W = 12;
    localparam int SPAN_W  = COORD_W + 1;
    localparam int COLOR_W = 32;
    localparam int CNT_W   = 32;
    localparam int AREA_W  = 2 * COORD_W;

    localparam logic [COORD_W-1:0] SCREEN_W_RST = 12'd640;
    localparam logic [COORD_W-1:0] SCREEN_H_RST = 12'd480;

    localparam int               HASH_SHL   = 5;
    localparam int               HASH_SHR   = 2;
    localparam logic [CNT_W-1:0] HASH_X_MUL = 32'd17;
    localparam logic [CNT_W-1:0] HASH_Y_MUL = 32'd31;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_PIXEL = 2'd1,
        MODE_RECT  = 2'd2,
        MODE_HASH  = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_SCREEN_W = 1'b0,
        CFG_SCREEN_H = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_mode               mode;
        logic [COORD_W-1:0]  pos_x;
        logic [COORD_W-1:0]  pos_y;
        logic [COORD_W-1:0]  rect_w;
        logic [COORD_W-1:0]  rect_h;
        logic [COLOR_W-1:0]  color;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0] hash;
        logic [CNT_W-1:0] pixel_total;
        logic [CNT_W-1:0] rect_total;
    } t_res;

    typedef struct packed {
        t_cfg_reg            index;
        logic [COORD_W-1:0]  value;
    } t_cfg;

    // Request from the sequencer to one axis scaler.
    typedef struct packed {
        logic                start;
        logic [SPAN_W-1:0]   coord;
        logic [COORD_W-1:0]  count;
        logic [COORD_W-1:0]  extent;
    } t_scale_req;

endpackage
`default_nettype wire

[design/srde_chan_if.sv]
// Valid/ready channel carrying one payload beat.
`default_nettype none
interface srde_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/srde_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module srde_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 5184
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[design/srde_div.sv]
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module srde_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo,
    output logic [DEN_W-1:0] o_rem
);
    localparam int CW = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             q_bit;

    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NUM_W);
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                // quotient bits shift in behind the numerator bits
                r_num <= {r_num[NUM_W-2:0], q_bit};
                r_rem <= q_bit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

[design/srde_scale.sv]
// Axis scaler: maps a span of logical coordinates onto raster cells.
`default_nettype none
module srde_scale #(
    parameter int CELLS = 96
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srde_pkg::t_scale_req         i_req,
    output logic                         o_busy,
    output logic [$clog2(CELLS)-1:0]     o_idx,
    output logic [CELLS-1:0]             o_hit
);
    import srde_pkg::*;

    localparam int QW = $clog2(CELLS);
    localparam int NW = SPAN_W + $clog2(CELLS);
    localparam int RW = COORD_W + 1;

    typedef enum logic [3:0] {
        SC_IDLE = 4'b0001,
        SC_MUL  = 4'b0010,
        SC_DIV  = 4'b0100,
        SC_STEP = 4'b1000
    } t_sc_state;

    t_sc_state          r_state;
    logic [SPAN_W-1:0]  r_coord;
    logic [COORD_W-1:0] r_left;
    logic [COORD_W-1:0] r_ext;
    logic [NW-1:0]      r_prod;
    logic               r_div_start;
    logic [QW-1:0]      r_q;
    logic [RW-1:0]      r_r;
    logic [QW-1:0]      r_idx;
    logic [CELLS-1:0]   r_hit;
    logic               div_done;
    logic [NW-1:0]      div_quo;
    logic [COORD_W-1:0] div_rem;

    srde_div #(
        .NUM_W (NW),
        .DEN_W (COORD_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_prod),
        .i_den   (r_ext),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SC_IDLE;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= r_state == SC_MUL;
            case (r_state)
                SC_IDLE: begin
                    if (i_req.start) begin
                        r_coord <= i_req.coord;
                        r_left  <= i_req.count;
                        r_ext   <= i_req.extent;
                        r_hit   <= '0;
                        r_state <= SC_MUL;
                    end
                end
                SC_MUL: begin
                    r_prod      <= NW'(r_coord * CELLS);
                    r_state     <= SC_DIV;
                end
                SC_DIV: begin
                    if (div_done) begin
                        if (div_quo >= NW'(CELLS - 1)) begin
                            // first point already clamps: so does the rest
                            r_idx            <= QW'(CELLS - 1);
                            r_hit[CELLS-1]   <= 1'b1;
                            r_state          <= SC_IDLE;
                        end else begin
                            r_idx   <= div_quo[QW-1:0];
                            r_q     <= div_quo[QW-1:0];
                            r_r     <= {1'b0, div_rem};
                            r_state <= SC_STEP;
                        end
                    end
                end
                SC_STEP: begin
                    // keep c*CELLS = q*ext + r while c walks the span
                    if (r_r >= {1'b0, r_ext}) begin
                        r_r <= r_r - {1'b0, r_ext};
                        if (r_q == QW'(CELLS - 2)) begin
                            r_hit[CELLS-1] <= 1'b1;
                            r_state        <= SC_IDLE;
                        end else begin
                            r_q <= r_q + 1'b1;
                        end
                    end else begin
                        r_hit[r_q] <= 1'b1;
                        if (r_left == COORD_W'(1)) begin
                            r_state <= SC_IDLE;
                        end else begin
                            r_left <= r_left - 1'b1;
                            r_r    <= r_r + RW'(CELLS);
                        end
                    end
                end
                default: r_state <= SC_IDLE;
            endcase
        end
    end

    assign o_busy = r_state != SC_IDLE;
    assign o_idx  = r_idx;
    assign o_hit  = r_hit;
endmodule
`default_nettype wire

[design/scaled_raster_draw_engine.sv]
// Top level: command sequencer around the raster RAM and two axis scalers.
// Clear and checksum walk every RAM address; a pixel write waits on the bit-serial divide
// in the axis scalers; a rect fill adds the scalers' stepping over the rect size and a walk
// over the whole RAM.
// One command in flight; the next is taken while a result waits in the output register.
// Reset: synchronous, counters zero, screen 640x480, then a pass over every address zeroes the RAM
// while commands are held off; configuration writes are always taken.
`default_nettype none
module scaled_raster_draw_engine #(
    parameter int RASTER_W = 96,
    parameter int RASTER_H = 54
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srde_chan_if.sink   i_cmd,
    srde_chan_if.source o_res,
    srde_chan_if.sink   i_cfg
);
    import srde_pkg::*;

    localparam int XW    = $clog2(RASTER_W);
    localparam int YW    = $clog2(RASTER_H);
    localparam int DEPTH = RASTER_W * RASTER_H;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCALE = 6'b000100,
        S_WALK  = 6'b001000,
        S_TAIL  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state               r_state;
    t_state               n_state;
    t_cmd                 r_cmd;
    logic [COORD_W-1:0]   r_scr_w;
    logic [COORD_W-1:0]   r_scr_h;
    logic [CNT_W-1:0]     r_pix_cnt;
    logic [CNT_W-1:0]     r_rect_cnt;
    logic [AREA_W-1:0]    r_area;
    logic [CNT_W-1:0]     r_hash;
    logic [CNT_W-1:0]     n_hash;
    logic [AW-1:0]        r_addr;
    logic [XW-1:0]        r_col;
    logic [YW-1:0]        r_row;
    logic                 r_rd_valid;
    logic [XW-1:0]        r_rd_col;
    logic [YW-1:0]        r_rd_row;
    t_scale_req           r_req_x;
    t_scale_req           r_req_y;
    logic                 r_out_valid;
    t_res                 r_out;

    logic                 cmd_acc;
    logic                 cfg_acc;
    logic                 out_free;
    logic                 drawable;
    logic                 nonempty;
    logic                 scale_go;
    logic                 last_addr;
    logic                 scale_fin;
    logic                 pix_commit;
    logic                 x_busy;
    logic                 y_busy;
    logic [XW-1:0]        x_idx;
    logic [YW-1:0]        y_idx;
    logic [RASTER_W-1:0]  col_hit;
    logic [RASTER_H-1:0]  row_hit;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [COLOR_W-1:0]   ram_wdata;
    logic [COLOR_W-1:0]   ram_rdata;
    logic [AW-1:0]        pix_addr;

    srde_scale #(.CELLS(RASTER_W)) u_scale_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req_x),
        .o_busy  (x_busy),
        .o_idx   (x_idx),
        .o_hit   (col_hit)
    );

    srde_scale #(.CELLS(RASTER_H)) u_scale_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req_y),
        .o_busy  (y_busy),
        .o_idx   (y_idx),
        .o_hit   (row_hit)
    );

    srde_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_raster (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready = r_state == S_IDLE;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    always_comb begin
        cmd_acc   = i_cmd.valid && i_cmd.ready;
        cfg_acc   = i_cfg.valid && i_cfg.ready;
        out_free  = !r_out_valid || o_res.ready;
        drawable  = (r_scr_w != '0) && (r_scr_h != '0);
        nonempty  = (i_cmd.data.rect_w != '0) && (i_cmd.data.rect_h != '0);
        scale_go  = cmd_acc && drawable && ((i_cmd.data.mode == MODE_PIXEL)
                 || ((i_cmd.data.mode == MODE_RECT) && nonempty));
        last_addr = r_addr == AW'(DEPTH - 1);
        // start pulse still pending means the scalers have not picked it up yet
        scale_fin = !r_req_x.start && !x_busy && !y_busy;
        pix_commit = (r_state == S_SCALE) && scale_fin && (r_cmd.mode == MODE_PIXEL);
        pix_addr  = AW'(y_idx * RASTER_W) + AW'(x_idx);

        ram_we    = (r_state == S_INIT) || pix_commit
                 || ((r_state == S_WALK) && ((r_cmd.mode == MODE_CLEAR)
                 || ((r_cmd.mode == MODE_RECT) && row_hit[r_row] && col_hit[r_col])));
        ram_waddr = pix_commit ? pix_addr : r_addr;
        ram_wdata = (r_state == S_INIT) ? '0 : r_cmd.color;

        n_hash = (r_hash << HASH_SHL) ^ (r_hash >> HASH_SHR) ^ ram_rdata
               ^ (CNT_W'(r_rd_col) * HASH_X_MUL) ^ (CNT_W'(r_rd_row) * HASH_Y_MUL);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (last_addr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (cmd_acc) begin
                    case (i_cmd.data.mode)
                        MODE_CLEAR, MODE_HASH: n_state = S_WALK;
                        MODE_PIXEL: n_state = drawable ? S_SCALE : S_DONE;
                        MODE_RECT:  n_state = (nonempty && drawable) ? S_SCALE : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SCALE: begin
                if (scale_fin) n_state = (r_cmd.mode == MODE_PIXEL) ? S_DONE : S_WALK;
            end
            S_WALK: begin
                if (last_addr) n_state = (r_cmd.mode == MODE_HASH) ? S_TAIL : S_DONE;
            end
            S_TAIL:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_scr_w       <= SCREEN_W_RST;
            r_scr_h       <= SCREEN_H_RST;
            r_pix_cnt     <= '0;
            r_rect_cnt    <= '0;
            r_addr        <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_rd_valid    <= 1'b0;
            r_req_x.start <= 1'b0;
            r_req_y.start <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_req_x.start <= scale_go;
            r_req_y.start <= scale_go;

            if (cfg_acc) begin
                case (i_cfg.data.index)
                    CFG_SCREEN_W: r_scr_w <= i_cfg.data.value;
                    CFG_SCREEN_H: r_scr_h <= i_cfg.data.value;
                    default: ;
                endcase
            end

            // cell position is registered alongside the RAM read, so the read beat lines up with it
            r_rd_valid <= (r_state == S_WALK) && (r_cmd.mode == MODE_HASH);
            r_rd_col   <= r_col;
            r_rd_row   <= r_row;
            if (r_rd_valid) begin
                r_hash <= n_hash;
            end

            case (r_state)
                S_INIT: begin
                    r_addr <= last_addr ? '0 : r_addr + 1'b1;
                end
                S_IDLE: begin
                    if (cmd_acc) begin
                        r_cmd          <= i_cmd.data;
                        r_hash         <= '0;
                        r_addr         <= '0;
                        r_col          <= '0;
                        r_row          <= '0;
                        r_area         <= i_cmd.data.rect_w * i_cmd.data.rect_h;
                        r_req_x.coord  <= SPAN_W'(i_cmd.data.pos_x);
                        r_req_y.coord  <= SPAN_W'(i_cmd.data.pos_y);
                        r_req_x.extent <= r_scr_w;
                        r_req_y.extent <= r_scr_h;
                        if (i_cmd.data.mode == MODE_PIXEL) begin
                            r_req_x.count <= COORD_W'(1);
                            r_req_y.count <= COORD_W'(1);
                        end else begin
                            r_req_x.count <= i_cmd.data.rect_w;
                            r_req_y.count <= i_cmd.data.rect_h;
                            if ((i_cmd.data.mode == MODE_RECT) && nonempty) begin
                                r_rect_cnt <= r_rect_cnt + 1'b1;
                            end
                        end
                    end
                end
                S_SCALE: begin
                    if (scale_fin) begin
                        if (r_cmd.mode == MODE_PIXEL) begin
                            r_pix_cnt <= r_pix_cnt + 1'b1;
                        end else begin
                            r_pix_cnt <= r_pix_cnt + CNT_W'(r_area);
                        end
                    end
                end
                S_WALK: begin
                    if (last_addr) begin
                        r_addr <= '0;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                        if (r_col == XW'(RASTER_W - 1)) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end
                end
                default: ;
            endcase

            if ((r_state == S_DONE) && out_free) begin
                r_out_valid       <= 1'b1;
                r_out.hash        <= (r_cmd.mode == MODE_HASH) ? r_hash : '0;
                r_out.pixel_total <= r_pix_cnt;
                r_out.rect_total  <= r_rect_cnt;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_hash_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && (r_cmd.mode == MODE_HASH) |-> !ram_we)
        else $error("raster written during checksum walk");

    a_pix_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_SCALE) |=> $stable(r_pix_cnt))
        else $error("pixel counter moved outside scale completion");

    a_rect_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |=> $stable(r_rect_cnt))
        else $error("rect counter moved outside command accept");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

endmodule
`default_nettype wire

[tb/sv/scaled_raster_draw_engine_tb.sv]
// Self-checking testbench for the scaled raster draw engine: directed and random draw commands.
`timescale 1ns / 1ps
module scaled_raster_draw_engine_tb;
    import srde_pkg::*;

    localparam int RW = 96;
    localparam int RH = 54;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    srde_chan_if #(.T(t_cmd)) cmd_ch ();
    srde_chan_if #(.T(t_res)) res_ch ();
    srde_chan_if #(.T(t_cfg)) cfg_ch ();

    scaled_raster_draw_engine #(
        .RASTER_W(RW),
        .RASTER_H(RH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow of the block's state
    logic [COLOR_W-1:0] raster [RH][RW];
    logic [CNT_W-1:0]   pixel_cnt;
    logic [CNT_W-1:0]   rect_cnt;
    logic [COORD_W-1:0] scr_w;
    logic [COORD_W-1:0] scr_h;

    t_res due_results [$];

    int  errors;
    int  results_seen;
    int  cfg_writes;
    int  mode_seen [4];
    bit  idle_on;
    int  hold_request;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int unsigned cell_of(input int unsigned c, input int unsigned cells,
                                            input int unsigned extent);
        int unsigned r;
        r = (c * cells) / extent;
        if (r >= cells) r = cells - 1;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] raster_checksum();
        logic [CNT_W-1:0] h;
        h = '0;
        for (int y = 0; y < RH; y++) begin
            for (int x = 0; x < RW; x++) begin
                h = (h << HASH_SHL) ^ (h >> HASH_SHR) ^ raster[y][x]
                    ^ (32'(x) * HASH_X_MUL) ^ (32'(y) * HASH_Y_MUL);
            end
        end
        return h;
    endfunction

    // Applies one command to the shadow raster and returns the result it must produce.
    function automatic t_res raster_draw(input t_cmd c);
        t_res r;
        bit   drawable;
        bit   col_hit [RW];
        bit   row_hit [RH];
        r = '0;
        drawable = (scr_w != 0) && (scr_h != 0);
        case (c.mode)
            MODE_CLEAR: begin
                for (int y = 0; y < RH; y++)
                    for (int x = 0; x < RW; x++) raster[y][x] = c.color;
            end
            MODE_PIXEL: begin
                if (drawable) begin
                    raster[cell_of(c.pos_y, RH, scr_h)][cell_of(c.pos_x, RW, scr_w)] = c.color;
                    pixel_cnt++;
                end
            end
            MODE_RECT: begin
                if (c.rect_w != 0 && c.rect_h != 0) begin
                    if (drawable) begin
                        col_hit = '{default: 1'b0};
                        row_hit = '{default: 1'b0};
                        // corner plus size may pass 4095; those points clamp too
                        for (int i = 0; i < c.rect_w; i++)
                            col_hit[cell_of(c.pos_x + i, RW, scr_w)] = 1'b1;
                        for (int i = 0; i < c.rect_h; i++)
                            row_hit[cell_of(c.pos_y + i, RH, scr_h)] = 1'b1;
                        for (int y = 0; y < RH; y++)
                            for (int x = 0; x < RW; x++)
                                if (row_hit[y] && col_hit[x]) raster[y][x] = c.color;
                        pixel_cnt += 32'(c.rect_w) * 32'(c.rect_h);
                    end
                    rect_cnt++;
                end
            end
            default: r.hash = raster_checksum();
        endcase
        r.pixel_total = pixel_cnt;
        r.rect_total  = rect_cnt;
        return r;
    endfunction

    function automatic t_cmd mk_cmd(input t_mode m, input int x, input int y, input int w,
                                    input int h, input logic [COLOR_W-1:0] col);
        t_cmd c;
        c.mode   = m;
        c.pos_x  = COORD_W'(x);
        c.pos_y  = COORD_W'(y);
        c.rect_w = COORD_W'(w);
        c.rect_h = COORD_W'(h);
        c.color  = col;
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 120);
    endfunction

    // Offers one command; returns at the accepting edge with valid still high.
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        due_results.push_back(raster_draw(c));
        mode_seen[c.mode]++;
    endtask

    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Call only when idle; writes both screen registers back to back.
    task automatic write_screen(input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{CFG_SCREEN_W, w};
        do @(posedge i_clk); while (!cfg_ch.ready);
        scr_w = w;
        cfg_ch.data  <= '{CFG_SCREEN_H, h};
        do @(posedge i_clk); while (!cfg_ch.ready);
        scr_h = h;
        cfg_ch.valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // Result side: compare every beat against the oldest prediction, idle at random.
    initial begin : result_sink
        int   gap_left;
        int   hold_left;
        int   g;
        t_res want;
        gap_left  = 0;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", res_ch.data));
                end else begin
                    want = due_results.pop_front();
                    if (res_ch.data.hash !== want.hash)
                        report_mismatch($sformatf("hash got %h want %h",
                                                  res_ch.data.hash, want.hash));
                    if (res_ch.data.pixel_total !== want.pixel_total)
                        report_mismatch($sformatf("pixel_total got %h want %h",
                                                  res_ch.data.pixel_total, want.pixel_total));
                    if (res_ch.data.rect_total !== want.rect_total)
                        report_mismatch($sformatf("rect_total got %h want %h",
                                                  res_ch.data.rect_total, want.rect_total));
                end
            end
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                res_ch.ready <= 1'b0;
            end else begin
                g = pick_gap();
                if (g > 0) begin
                    gap_left = g - 1;
                    res_ch.ready <= 1'b0;
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    task automatic test_reset_state();
        // raster must read back as cleared after reset
        send_cmd(mk_cmd(MODE_HASH, 0, 0, 0, 0, '0));
    endtask

    task automatic test_clear_fill();
        send_cmd(mk_cmd(MODE_CLEAR, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(MODE_HASH, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(MODE_CLEAR, 4095, 4095, 4095, 4095, 32'hA5A5_5A5A));
        send_cmd(mk_cmd(MODE_HASH, 0, 0, 0, 0, '0));
    endtask

    task automatic test_pixel_corners();
        send_cmd(mk_cmd(MODE_PIXEL, 0, 0, 0, 0, 32'hFFFF_FFFF));
        send_cmd(mk_cmd(MODE_PIXEL, 639, 479, 0, 0, 32'h1234_5678));
        send_cmd(mk_cmd(MODE_PIXEL, 4095, 4095, 4095, 4095, 32'h0000_0000));
        send_cmd(mk_cmd(MODE_PIXEL, 320, 240, 0, 0, 32'hDEAD_BEEF));
        send_cmd(mk_cmd(MODE_HASH, 0, 0, 0, 0, '0));
    endtask

    task automatic test_rect_edges();
        send_cmd(mk_cmd(MODE_RECT, 10, 10, 0, 5, 32'h1111_1111));
        send_cmd(mk_cmd(MODE_RECT, 10, 10, 5, 0, 32'h2222_2222));
        send_cmd(mk_cmd(MODE_RECT, 4095, 4095, 4095, 4095, 32'h3333_3333));
        send_cmd(mk_cmd(MODE_RECT, 0, 0, 10, 10, 32'h4444_4444));
        send_cmd(mk_cmd(MODE_RECT, 100, 50, 1, 1, 32'h5555_5555));
        send_cmd(mk_cmd(MODE_HASH, 0, 0, 0, 0, '0));
    endtask

    task automatic test_zero_screen();
        wait_idle();
        write_screen(12'd0, 12'd480);
        send_cmd(mk_cmd(MODE_PIXEL, 5, 5, 0, 0, 32'h6666_6666));
        send_cmd(mk_cmd(MODE_RECT, 5, 5, 3, 3, 32'h7777_7777));
        send_cmd(mk_cmd(MODE_HASH, 0, 0, 0, 0, '0));
        wait_idle();
        write_screen(12'd640, 12'd0);
        send_cmd(mk_cmd(MODE_PIXEL, 5, 5, 0, 0, 32'h8888_8888));
        send_cmd(mk_cmd(MODE_RECT, 5, 5, 3, 3, 32'h9999_9999));
        send_cmd(mk_cmd(MODE_HASH, 0, 0, 0, 0, '0));
        wait_idle();
        write_screen(12'd4095, 12'd4095);
        send_cmd(mk_cmd(MODE_PIXEL, 4095, 4095, 0, 0, 32'hCAFE_F00D));
        send_cmd(mk_cmd(MODE_HASH, 0, 0, 0, 0, '0));
    endtask

    task automatic test_backpressure();
        wait_idle();
        idle_on = 1'b0;
        // sink stalls while commands keep coming, so the input must back up
        hold_request = 400;
        for (int k = 0; k < 12; k++)
            send_cmd(mk_cmd(MODE_PIXEL, $urandom_range(0, 4095), $urandom_range(0, 4095),
                            0, 0, $urandom));
        send_cmd(mk_cmd(MODE_HASH, 0, 0, 0, 0, '0));
        wait_idle();
    endtask

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   r;
        int   s;
        r = $urandom_range(0, 99);
        if (r < 5)       c.mode = MODE_CLEAR;
        else if (r < 70) c.mode = MODE_PIXEL;
        else if (r < 88) c.mode = MODE_RECT;
        else             c.mode = MODE_HASH;
        // mostly on screen, some anywhere in the coordinate range
        if ($urandom_range(0, 4) != 0 && scr_w != 0 && scr_h != 0) begin
            c.pos_x = COORD_W'($urandom_range(0, scr_w - 1));
            c.pos_y = COORD_W'($urandom_range(0, scr_h - 1));
        end else begin
            c.pos_x = COORD_W'($urandom_range(0, 4095));
            c.pos_y = COORD_W'($urandom_range(0, 4095));
        end
        s = $urandom_range(0, 99);
        if (s < 5) begin
            c.rect_w = $urandom_range(0, 1) ? '0 : COORD_W'($urandom_range(1, 4095));
            c.rect_h = (c.rect_w == 0) ? COORD_W'($urandom_range(0, 4095)) : '0;
        end else if (s < 90) begin
            c.rect_w = COORD_W'($urandom_range(1, 48));
            c.rect_h = COORD_W'($urandom_range(1, 48));
        end else begin
            c.rect_w = COORD_W'($urandom_range(1, 4095));
            c.rect_h = COORD_W'($urandom_range(1, 4095));
        end
        c.color = $urandom;
        return c;
    endfunction

    task automatic test_random_phases();
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
        for (int p = 0; p < 10; p++) begin
            wait_idle();
            case (p)
                0: begin w = 12'd640;  h = 12'd480;  end
                1: begin w = 12'd4095; h = 12'd4095; end
                2: begin w = 12'd1;    h = 12'd1;    end
                3: begin w = 12'd96;   h = 12'd54;   end
                4: begin w = 12'd0;    h = COORD_W'($urandom_range(1, 4095)); end
                5: begin w = COORD_W'($urandom_range(1, 4095)); h = 12'd0;    end
                6: begin
                    w = COORD_W'($urandom_range(1, 200));
                    h = COORD_W'($urandom_range(1, 200));
                end
                default: begin
                    w = COORD_W'($urandom_range(1, 4095));
                    h = COORD_W'($urandom_range(1, 4095));
                end
            endcase
            write_screen(w, h);
            idle_on = (p == 0 || p == 5) ? 1'b0 : 1'b1;
            for (int k = 0; k < 38; k++) send_cmd(rand_cmd());
            send_cmd(mk_cmd(MODE_HASH, 0, 0, 0, 0, '0));
        end
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        for (int y = 0; y < RH; y++)
            for (int x = 0; x < RW; x++) raster[y][x] = '0;
        pixel_cnt    = '0;
        rect_cnt     = '0;
        scr_w        = SCREEN_W_RST;
        scr_h        = SCREEN_H_RST;
        errors       = 0;
        results_seen = 0;
        cfg_writes   = 0;
        mode_seen    = '{default: 0};
        idle_on      = 1'b1;
        hold_request = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_clear_fill();
        test_pixel_corners();
        test_rect_edges();
        test_zero_screen();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));

        $display("covered: %0d clears, %0d pixel writes, %0d rect fills, %0d checksums",
                 mode_seen[MODE_CLEAR], mode_seen[MODE_PIXEL], mode_seen[MODE_RECT],
                 mode_seen[MODE_HASH]);
        $display("%0d results checked, %0d register writes, %0d mismatches",
                 results_seen, cfg_writes, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #(150_000_000);
        $display("timeout with %0d results outstanding", due_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule
